// File: rtl/ocit_pkg.sv
// Shared constants for the orthographic/isometric camera transform unit.
package ocit_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int ZOOM_FRAC  = 16;
   localparam int ZOOM_W     = 23;
   localparam int VP_W       = 14;
   localparam int CRD_W      = 32;
   localparam int K_W        = 30;
   localparam int KQ         = 30;
   localparam int ISO_LIM_EXP = 34;

   localparam logic [ZOOM_W-1:0] ZOOM_MIN = 23'd3277;
   localparam logic [ZOOM_W-1:0] ZOOM_RST = 23'd65536;
   localparam logic [VP_W-1:0]   VPW_RST  = 14'd1024;
   localparam logic [VP_W-1:0]   VPH_RST  = 14'd768;
   localparam logic [K_W-1:0]    INV_SQRT2 = 30'd759250125;

   localparam int HX_W  = VP_W + FRAC_BITS - 1;
   localparam int DW    = ((HX_W > CRD_W) ? HX_W : CRD_W) + 1;
   localparam int MW    = DW + 2;
   localparam int KM_W  = (MW > ISO_LIM_EXP + 1) ? MW : ISO_LIM_EXP + 1;
   localparam int PW    = KM_W + K_W;
   localparam int ZP    = KM_W + ZOOM_W;
   localparam int NUM_W = DW + ZOOM_FRAC;
   localparam int QW    = NUM_W + 1;
   localparam int RW    = 64;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_VP_W   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VP_H   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAM_X  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAM_Y  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ZOOM   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ISO    = 3'd5;

   localparam logic ACT_W2S = 1'b0;
   localparam logic ACT_S2W = 1'b1;

endpackage

// File: rtl/ortho_iso_camera_transform_unit.sv
// Orthographic/isometric 2D camera transform: one point per clock when not stalled.
// Accepts one transaction per clock and returns one result per transaction, in order,
// while the result side does not stall. Most of the pipeline depth comes from the
// 49-stage restoring divider used for screen to world; world to screen points travel
// the same pipeline. A stall on the result side freezes the whole pipeline.
module ortho_iso_camera_transform_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [63:0]                        req_tdata,  // x_in[31:0], y_in[63:32]
   input  logic [0:0]                         req_tuser,  // action
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [63:0]                        rsp_tdata,  // x_out[31:0], y_out[63:32]
   output logic [0:0]                         rsp_tuser,  // saturated
   input  logic                               csr_we,
   input  logic [ocit_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ocit_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ocit_pkg::*;

   typedef struct packed {
      logic            valid;
      logic            act;
      logic            sg0;
      logic            sg1;
      logic [KM_W-1:0] mg0;
      logic [KM_W-1:0] mg1;
   } sb_type;

   typedef struct packed {
      logic                 valid;
      logic                 act;
      logic                 sg0;
      logic                 sg1;
      logic signed [RW-1:0] fw0;
      logic signed [RW-1:0] fw1;
   } dl_type;

   typedef struct packed {
      logic                 valid;
      logic                 act;
      logic                 ag;
      logic                 bg;
      logic [KM_W-1:0]      am;
      logic [KM_W-1:0]      bm;
      logic signed [RW-1:0] v0;
      logic signed [RW-1:0] v1;
   } s9_type;

   localparam logic signed [RW-1:0] SAT_HI  = RW'(2147483647);
   localparam logic signed [RW-1:0] SAT_LO  = -SAT_HI - RW'(1);
   localparam logic signed [QW:0]   ISO_LIM = signed'((QW+1)'(1) << ISO_LIM_EXP);

   logic [VP_W-1:0]          vpw_ff;
   logic [VP_W-1:0]          vph_ff;
   logic signed [CRD_W-1:0]  camx_ff;
   logic signed [CRD_W-1:0]  camy_ff;
   logic [ZOOM_W-1:0]        zoom_ff;
   logic                     iso_ff;
   logic [ZOOM_W-1:0]        zoom_wr;
   logic [HX_W-1:0]          hx;
   logic [HX_W-1:0]          hy;
   logic                     adv;

   logic                     v1_ff;
   logic                     act1_ff;
   logic signed [CRD_W-1:0]  x1_ff;
   logic signed [CRD_W-1:0]  y1_ff;

   logic                     v2_ff;
   logic                     act2_ff;
   logic signed [DW-1:0]     d0_ff;
   logic signed [DW-1:0]     d1_ff;
   logic signed [DW-1:0]     d0_in;
   logic signed [DW-1:0]     d1_in;

   sb_type                   sb3_ff, sb3_in, sb4_ff, sb5_ff, sb6_ff, sb6_in, sb7_ff;
   logic signed [MW-1:0]     u0;
   logic signed [MW-1:0]     u1;
   logic [PW-1:0]            pa0;
   logic [PW-1:0]            pa1;
   logic [PW-1:0]            rnd0;
   logic [PW-1:0]            rnd1;
   logic [ZP-1:0]            pz0_ff;
   logic [ZP-1:0]            pz1_ff;
   logic [ZP-1:0]            rz0;
   logic [ZP-1:0]            rz1;
   logic signed [RW-1:0]     m0;
   logic signed [RW-1:0]     m1;

   dl_type                   dl8_ff, dl8_in;
   dl_type                   dl_ff [NUM_W];
   dl_type                   dlt;
   logic [NUM_W-1:0]         num0_ff, num0_in;
   logic [NUM_W-1:0]         num1_ff, num1_in;
   logic [NUM_W-1:0]         q0;
   logic [NUM_W-1:0]         q1;

   logic signed [QW-1:0]     qs0, qs1, qx, qy;
   logic signed [QW:0]       a_raw, b_raw, a_cl, b_cl;
   s9_type                   s9_ff, s9_in, s10_ff, s11_ff;
   logic [PW-1:0]            pb0;
   logic [PW-1:0]            pb1;
   logic [PW-1:0]            ra;
   logic [PW-1:0]            rb;
   logic signed [RW-1:0]     mva;
   logic signed [RW-1:0]     mvb;

   logic                     v12_ff;
   logic signed [RW-1:0]     fin0_ff, fin0_in;
   logic signed [RW-1:0]     fin1_ff, fin1_in;

   logic                     rsp_valid_ff;
   logic [CRD_W-1:0]         xo_ff, xo_in;
   logic [CRD_W-1:0]         yo_ff, yo_in;
   logic                     sat_ff, sat_in;

   // configuration
   assign zoom_wr = (csr_wdata[ZOOM_W-1:0] < ZOOM_MIN) ? ZOOM_MIN : csr_wdata[ZOOM_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vpw_ff  <= VPW_RST;
         vph_ff  <= VPH_RST;
         camx_ff <= '0;
         camy_ff <= '0;
         zoom_ff <= ZOOM_RST;
         iso_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VP_W:  vpw_ff  <= csr_wdata[VP_W-1:0];
            CSR_VP_H:  vph_ff  <= csr_wdata[VP_W-1:0];
            CSR_CAM_X: camx_ff <= signed'(csr_wdata[CRD_W-1:0]);
            CSR_CAM_Y: camy_ff <= signed'(csr_wdata[CRD_W-1:0]);
            CSR_ZOOM:  zoom_ff <= zoom_wr;
            CSR_ISO:   iso_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign hx  = HX_W'(vpw_ff) << (FRAC_BITS - 1);
   assign hy  = HX_W'(vph_ff) << (FRAC_BITS - 1);
   assign adv = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // stage 1: capture
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         act1_ff <= req_tuser[0];
         x1_ff   <= signed'(req_tdata[31:0]);
         y1_ff   <= signed'(req_tdata[63:32]);
      end
   end

   // stage 2: offsets
   always_comb begin
      if (act1_ff == ACT_W2S) begin
         d0_in = DW'(x1_ff) - DW'(camx_ff);
         d1_in = DW'(y1_ff) - DW'(camy_ff);
      end else begin
         d0_in = DW'(x1_ff) - signed'(DW'(hx));
         d1_in = DW'(y1_ff) - signed'(DW'(hy));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         act2_ff <= act1_ff;
         d0_ff   <= d0_in;
         d1_ff   <= d1_in;
      end
   end

   // stage 3: isometric mix, sign and magnitude
   always_comb begin
      if (act2_ff == ACT_W2S && iso_ff) begin
         u0 = (MW'(d0_ff) <<< 1) - MW'(d1_ff);
         u1 = (MW'(d0_ff) <<< 1) + MW'(d1_ff);
      end else begin
         u0 = MW'(d0_ff);
         u1 = MW'(d1_ff);
      end
      sb3_in.valid = v2_ff;
      sb3_in.act   = act2_ff;
      sb3_in.sg0   = u0[MW-1];
      sb3_in.sg1   = u1[MW-1];
      sb3_in.mg0   = KM_W'(unsigned'(u0[MW-1] ? -u0 : u0));
      sb3_in.mg1   = KM_W'(unsigned'(u1[MW-1] ? -u1 : u1));
   end

   ocit_kmul u_ka0 (.clock(clock), .adv(adv), .mag_in(sb3_ff.mg0), .prod_out(pa0));
   ocit_kmul u_ka1 (.clock(clock), .adv(adv), .mag_in(sb3_ff.mg1), .prod_out(pa1));

   // stage 6: round the 1/sqrt(2) product with the halving
   always_comb begin
      sb6_in = sb5_ff;
      rnd0   = pa0 + (PW'(1) << KQ);
      rnd1   = pa1 + (PW'(1) << KQ);
      if (sb5_ff.act == ACT_W2S && iso_ff) begin
         sb6_in.mg0 = KM_W'(rnd0 >> (KQ + 1));
         sb6_in.mg1 = KM_W'(rnd1 >> (KQ + 1));
      end
   end

   // stage 8: zoom rounding and half viewport, divider operands
   always_comb begin
      rz0 = pz0_ff + (ZP'(1) << (ZOOM_FRAC - 1));
      rz1 = pz1_ff + (ZP'(1) << (ZOOM_FRAC - 1));
      m0  = signed'(RW'(rz0 >> ZOOM_FRAC));
      m1  = signed'(RW'(rz1 >> ZOOM_FRAC));
      dl8_in.valid = sb7_ff.valid;
      dl8_in.act   = sb7_ff.act;
      dl8_in.sg0   = sb7_ff.sg0;
      dl8_in.sg1   = sb7_ff.sg1;
      dl8_in.fw0   = (sb7_ff.sg0 ? -m0 : m0) + signed'(RW'(hx));
      dl8_in.fw1   = (sb7_ff.sg1 ? -m1 : m1) + signed'(RW'(hy));
      num0_in = (NUM_W'(sb7_ff.mg0[DW-2:0]) << ZOOM_FRAC) + NUM_W'(zoom_ff >> 1);
      num1_in = (NUM_W'(sb7_ff.mg1[DW-2:0]) << ZOOM_FRAC) + NUM_W'(zoom_ff >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sb3_ff.valid <= 1'b0;
         sb4_ff.valid <= 1'b0;
         sb5_ff.valid <= 1'b0;
         sb6_ff.valid <= 1'b0;
         sb7_ff.valid <= 1'b0;
         dl8_ff.valid <= 1'b0;
      end else if (adv) begin
         sb3_ff <= sb3_in;
         sb4_ff <= sb3_ff;
         sb5_ff <= sb4_ff;
         sb6_ff <= sb6_in;
         sb7_ff <= sb6_ff;
         dl8_ff <= dl8_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pz0_ff  <= ZP'(sb6_ff.mg0) * ZP'(zoom_ff);
         pz1_ff  <= ZP'(sb6_ff.mg1) * ZP'(zoom_ff);
         num0_ff <= num0_in;
         num1_ff <= num1_in;
      end
   end

   ocit_div u_div0 (.clock(clock), .adv(adv), .num_in(num0_ff), .den(zoom_ff), .quo_out(q0));
   ocit_div u_div1 (.clock(clock), .adv(adv), .num_in(num1_ff), .den(zoom_ff), .quo_out(q1));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_W; i++) begin
            dl_ff[i].valid <= 1'b0;
         end
      end else if (adv) begin
         dl_ff[0] <= dl8_ff;
         for (int i = 1; i < NUM_W; i++) begin
            dl_ff[i] <= dl_ff[i-1];
         end
      end
   end

   assign dlt = dl_ff[NUM_W-1];

   // stage 9: signed quotients, plain result, isometric sums
   always_comb begin
      qs0   = signed'({1'b0, q0});
      qs1   = signed'({1'b0, q1});
      qx    = dlt.sg0 ? -qs0 : qs0;
      qy    = dlt.sg1 ? -qs1 : qs1;
      a_raw = (QW+1)'(qx) + (QW+1)'(qy);
      b_raw = (QW+1)'(qy) - (QW+1)'(qx);
      a_cl  = (a_raw > ISO_LIM) ? ISO_LIM : ((a_raw < -ISO_LIM) ? -ISO_LIM : a_raw);
      b_cl  = (b_raw > ISO_LIM) ? ISO_LIM : ((b_raw < -ISO_LIM) ? -ISO_LIM : b_raw);
      s9_in.valid = dlt.valid;
      s9_in.act   = dlt.act;
      s9_in.ag    = a_cl[QW];
      s9_in.bg    = b_cl[QW];
      s9_in.am    = KM_W'(unsigned'(a_cl[QW] ? -a_cl : a_cl));
      s9_in.bm    = KM_W'(unsigned'(b_cl[QW] ? -b_cl : b_cl));
      if (dlt.act == ACT_W2S) begin
         s9_in.v0 = dlt.fw0;
         s9_in.v1 = dlt.fw1;
      end else begin
         s9_in.v0 = RW'(camx_ff) + RW'(qx);
         s9_in.v1 = RW'(camy_ff) + RW'(qy);
      end
   end

   ocit_kmul u_kb0 (.clock(clock), .adv(adv), .mag_in(s9_ff.am), .prod_out(pb0));
   ocit_kmul u_kb1 (.clock(clock), .adv(adv), .mag_in(s9_ff.bm), .prod_out(pb1));

   // stage 12: isometric screen to world rotates back and adds camera; others pass through
   always_comb begin
      ra  = pb0 + (PW'(1) << (KQ - 1));
      rb  = pb1 + (PW'(1) << (KQ - 2));
      mva = signed'(RW'(ra >> KQ));
      mvb = signed'(RW'(rb >> (KQ - 1)));
      if (s11_ff.act == ACT_S2W && iso_ff) begin
         fin0_in = RW'(camx_ff) + (s11_ff.ag ? -mva : mva);
         fin1_in = RW'(camy_ff) + (s11_ff.bg ? -mvb : mvb);
      end else begin
         fin0_in = s11_ff.v0;
         fin1_in = s11_ff.v1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_ff.valid  <= 1'b0;
         s10_ff.valid <= 1'b0;
         s11_ff.valid <= 1'b0;
         v12_ff       <= 1'b0;
      end else if (adv) begin
         s9_ff  <= s9_in;
         s10_ff <= s9_ff;
         s11_ff <= s10_ff;
         v12_ff <= s11_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fin0_ff <= fin0_in;
         fin1_ff <= fin1_in;
      end
   end

   // output register: saturate
   always_comb begin
      sat_in = 1'b0;
      if (fin0_ff > SAT_HI) begin
         xo_in  = SAT_HI[CRD_W-1:0];
         sat_in = 1'b1;
      end else if (fin0_ff < SAT_LO) begin
         xo_in  = SAT_LO[CRD_W-1:0];
         sat_in = 1'b1;
      end else begin
         xo_in  = fin0_ff[CRD_W-1:0];
      end
      if (fin1_ff > SAT_HI) begin
         yo_in  = SAT_HI[CRD_W-1:0];
         sat_in = 1'b1;
      end else if (fin1_ff < SAT_LO) begin
         yo_in  = SAT_LO[CRD_W-1:0];
         sat_in = 1'b1;
      end else begin
         yo_in  = fin1_ff[CRD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v12_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         xo_ff  <= xo_in;
         yo_ff  <= yo_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {yo_ff, xo_ff};
   assign rsp_tuser[0] = sat_ff;

   a_zoom_floor: assert property (@(posedge clock) disable iff (reset)
      zoom_ff >= ZOOM_MIN)
      else $error("zoom register below floor");

   a_zoom_clamp: assert property (@(posedge clock) disable iff (reset)
      (csr_we && csr_index == CSR_ZOOM && csr_wdata[ZOOM_W-1:0] < ZOOM_MIN)
      |=> zoom_ff == ZOOM_MIN)
      else $error("small zoom write not clamped");

   a_sat_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && sat_ff) |->
      (xo_ff == SAT_HI[CRD_W-1:0] || xo_ff == SAT_LO[CRD_W-1:0] ||
       yo_ff == SAT_HI[CRD_W-1:0] || yo_ff == SAT_LO[CRD_W-1:0]))
      else $error("saturation flag without clipped coordinate");

endmodule

// File: rtl/ocit_kmul.sv
// Two-stage multiplier of a magnitude by 1/sqrt(2) in Q30, split in partial products.
module ocit_kmul (
   input  logic                        clock,
   input  logic                        adv,
   input  logic [ocit_pkg::KM_W-1:0]   mag_in,
   output logic [ocit_pkg::PW-1:0]     prod_out
);
   import ocit_pkg::*;

   localparam int LO_W = KM_W / 2;
   localparam int HI_W = KM_W - LO_W;

   logic [LO_W+K_W-1:0] lo_ff;
   logic [LO_W+K_W-1:0] lo_in;
   logic [HI_W+K_W-1:0] hi_ff;
   logic [HI_W+K_W-1:0] hi_in;
   logic [PW-1:0]       prod_ff;
   logic [PW-1:0]       prod_in;

   assign lo_in   = (LO_W+K_W)'(mag_in[LO_W-1:0]) * (LO_W+K_W)'(INV_SQRT2);
   assign hi_in   = (HI_W+K_W)'(mag_in[KM_W-1:LO_W]) * (HI_W+K_W)'(INV_SQRT2);
   assign prod_in = (PW'(hi_ff) << LO_W) + PW'(lo_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         prod_ff <= prod_in;
      end
   end

   assign prod_out = prod_ff;

endmodule

// File: rtl/ocit_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module ocit_div (
   input  logic                         clock,
   input  logic                         adv,
   input  logic [ocit_pkg::NUM_W-1:0]   num_in,
   input  logic [ocit_pkg::ZOOM_W-1:0]  den,
   output logic [ocit_pkg::NUM_W-1:0]   quo_out
);
   import ocit_pkg::*;

   logic [ZOOM_W-1:0] rem_ff [NUM_W];
   logic [NUM_W-1:0]  nq_ff  [NUM_W];

   for (genvar i = 0; i < NUM_W; i++) begin : g_st
      logic [ZOOM_W-1:0] r_src;
      logic [NUM_W-1:0]  n_src;
      logic [ZOOM_W:0]   t;
      logic [ZOOM_W:0]   diff;
      logic              ge;
      logic [ZOOM_W-1:0] rem_in;
      logic [NUM_W-1:0]  nq_in;

      if (i == 0) begin : g_first
         assign r_src = '0;
         assign n_src = num_in;
      end else begin : g_next
         assign r_src = rem_ff[i-1];
         assign n_src = nq_ff[i-1];
      end

      assign t      = {r_src, n_src[NUM_W-1]};
      assign diff   = t - {1'b0, den};
      assign ge     = (t >= {1'b0, den});
      assign rem_in = ge ? diff[ZOOM_W-1:0] : t[ZOOM_W-1:0];
      assign nq_in  = {n_src[NUM_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[i] <= rem_in;
            nq_ff[i]  <= nq_in;
         end
      end
   end

   assign quo_out = nq_ff[NUM_W-1];

endmodule

// File: bench/tb_ortho_iso_camera_transform_unit.sv
// Self-checking bench for the orthographic/isometric camera transform unit.
`timescale 1ns / 1ps

module tb_ortho_iso_camera_transform_unit;
   import ocit_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 80;
   localparam logic [31:0] K_Q30 = 32'd759250125;
   localparam logic signed [127:0] ISO_CLAMP = 128'sd1 <<< ISO_LIM_EXP;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic        sat;
   } point_type;

   class camera_scoreboard;
      logic [VP_W-1:0]   vp_w;
      logic [VP_W-1:0]   vp_h;
      logic [31:0]       cam_x;
      logic [31:0]       cam_y;
      logic [ZOOM_W-1:0] zoom;
      logic              iso;
      bit                clip;
      int                errors;
      point_type         mapped_q[$];

      function new();
         vp_w = VPW_RST;
         vp_h = VPH_RST;
         cam_x = 0;
         cam_y = 0;
         zoom = ZOOM_RST;
         iso = 0;
         errors = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
         case (idx)
            CSR_VP_W:  vp_w = val[VP_W-1:0];
            CSR_VP_H:  vp_h = val[VP_W-1:0];
            CSR_CAM_X: cam_x = val;
            CSR_CAM_Y: cam_y = val;
            CSR_ZOOM: begin
               zoom = val[ZOOM_W-1:0];
               if (zoom < ZOOM_MIN) zoom = ZOOM_MIN;
            end
            CSR_ISO:   iso = val[0];
            default: ;
         endcase
      endfunction

      function logic signed [127:0] mul_rnd(logic signed [127:0] a, logic [127:0] m, int sh);
         logic [127:0] mag;
         logic [127:0] r;
         mag = (a < 0) ? -a : a;
         r = (mag * m + (128'd1 << (sh - 1))) >> sh;
         return (a < 0) ? -$signed(r) : $signed(r);
      endfunction

      function logic signed [127:0] div_rnd(logic signed [127:0] a, logic [127:0] d);
         logic [127:0] n;
         logic [127:0] r;
         n = ((a < 0) ? -a : a) << ZOOM_FRAC;
         r = (n + d / 2) / d;
         return (a < 0) ? -$signed(r) : $signed(r);
      endfunction

      function logic signed [127:0] iso_lim(logic signed [127:0] v);
         if (v > ISO_CLAMP) return ISO_CLAMP;
         if (v < -ISO_CLAMP) return -ISO_CLAMP;
         return v;
      endfunction

      function logic [31:0] sat32(logic signed [127:0] v);
         if (v > 128'sh7FFFFFFF) begin
            clip = 1;
            return 32'h7FFFFFFF;
         end
         if (v < -128'sh80000000) begin
            clip = 1;
            return 32'h80000000;
         end
         return v[31:0];
      endfunction

      function void note_point(logic act, logic [31:0] xi, logic [31:0] yi);
         logic signed [127:0] x, y, cx, cy, hx, hy, rx, ry, qx, qy, a, b;
         point_type p;
         x = $signed(xi);
         y = $signed(yi);
         cx = $signed(cam_x);
         cy = $signed(cam_y);
         hx = $signed({114'd0, vp_w}) <<< (FRAC_BITS - 1);
         hy = $signed({114'd0, vp_h}) <<< (FRAC_BITS - 1);
         clip = 0;
         if (act == ACT_W2S) begin
            rx = x - cx;
            ry = y - cy;
            if (iso) begin
               a = 2 * rx - ry;
               b = 2 * rx + ry;
               rx = mul_rnd(a, K_Q30, 31);
               ry = mul_rnd(b, K_Q30, 31);
            end
            rx = mul_rnd(rx, zoom, ZOOM_FRAC) + hx;
            ry = mul_rnd(ry, zoom, ZOOM_FRAC) + hy;
         end else begin
            qx = div_rnd(x - hx, zoom);
            qy = div_rnd(y - hy, zoom);
            if (iso) begin
               a = iso_lim(qx + qy);
               b = iso_lim(qy - qx);
               rx = cx + mul_rnd(a, K_Q30, 30);
               ry = cy + mul_rnd(b, K_Q30, 29);
            end else begin
               rx = cx + qx;
               ry = cy + qy;
            end
         end
         p.x = sat32(rx);
         p.y = sat32(ry);
         p.sat = clip;
         mapped_q.push_back(p);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch %s: got %h expected %h", what, got, want);
         errors++;
      endtask

      task check_point(logic [31:0] x, logic [31:0] y, logic sat);
         point_type p;
         if (mapped_q.size() == 0) begin
            report("unexpected transaction", x, 0);
         end else begin
            p = mapped_q.pop_front();
            if (x !== p.x) report("x_out", x, p.x);
            if (y !== p.y) report("y_out", y, p.y);
            if (sat !== p.sat) report("saturated", sat, p.sat);
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [63:0]           req_tdata;
   logic [0:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [63:0]           rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   camera_scoreboard sb = new();
   bit  calm;
   int  cycles;

   ortho_iso_camera_transform_unit dut (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_point(req_tuser[0], req_tdata[31:0], req_tdata[63:32]);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_point(rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser[0]);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         gap = calm ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task send_point(logic act, logic [31:0] x, logic [31:0] y);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {y, x};
      req_tuser <= act;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.mapped_q.size() != 0) @(posedge clock);
   endtask

   task csr_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   function logic [31:0] pick_coord(logic [VP_W-1:0] vp);
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $urandom_range(0, 32'h01FFFFFF) - 32'h01000000;
         2: return $urandom_range(0, {vp, 16'h0});
         3: return $urandom_range(0, 3) == 0 ? 32'h7FFFFFFF : 32'h80000000 + $urandom_range(0, 3);
         default: return $urandom_range(0, 32'h1FFFFF) - 32'h100000;
      endcase
   endfunction

   task directed_batch();
      send_point(ACT_W2S, 32'h0, 32'h0);
      send_point(ACT_S2W, 32'h0, 32'h0);
      send_point(ACT_W2S, 32'h7FFFFFFF, 32'h80000000);
      send_point(ACT_S2W, 32'h80000000, 32'h7FFFFFFF);
      send_point(ACT_W2S, 32'hFFFFFFFF, 32'h00000001);
      send_point(ACT_S2W, 32'h02000000, 32'h01800000);
      send_point(ACT_W2S, 32'h80000000, 32'h80000000);
      send_point(ACT_S2W, 32'h7FFFFFFF, 32'hFFFFFFFF);
      drain();
   endtask

   initial begin
      logic [31:0] v;
      cycles = 0;
      calm = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_batch();
      csr_write(CSR_ISO, 32'hFFFFFFFF);
      csr_write(CSR_ZOOM, 32'hFFFFFFFF);
      csr_write(CSR_CAM_X, 32'h80000000);
      csr_write(CSR_CAM_Y, 32'h7FFFFFFF);
      directed_batch();
      csr_write(CSR_ZOOM, 32'd100);
      csr_write(CSR_VP_W, 32'hFFFFC000);
      csr_write(CSR_VP_H, 32'h00003FFF);
      csr_write(3'd6, 32'h12345678);
      csr_write(3'd7, 32'hFFFFFFFF);
      directed_batch();

      for (int ph = 0; ph < 10; ph++) begin
         calm = (ph % 3 == 1);
         v = $urandom_range(0, 3) == 0 ? (ph[0] ? 32'd16383 : 32'd1) : $urandom_range(1, 4096);
         csr_write(CSR_VP_W, v);
         v = $urandom_range(0, 3) == 0 ? (ph[1] ? 32'd16383 : 32'd0) : $urandom_range(1, 4096);
         csr_write(CSR_VP_H, v);
         v = $urandom_range(0, 3) == 0 ? (ph[0] ? 32'h7FFFFFFF : 32'h80000000) : pick_coord(14'd512);
         csr_write(CSR_CAM_X, v);
         v = $urandom_range(0, 3) == 0 ? (ph[1] ? 32'h80000000 : 32'h7FFFFFFF) : pick_coord(14'd512);
         csr_write(CSR_CAM_Y, v);
         case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 4000);
            1: v = 32'h007FFFFF;
            default: v = $urandom_range(3277, 262144);
         endcase
         csr_write(CSR_ZOOM, v);
         csr_write(CSR_ISO, $urandom);
         repeat (95) send_point($urandom_range(0, 1), pick_coord(sb.vp_w), pick_coord(sb.vp_h));
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.mapped_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: ortho_iso_camera_transform_unit.f
rtl/ocit_pkg.sv
rtl/ocit_kmul.sv
rtl/ocit_div.sv
rtl/ortho_iso_camera_transform_unit.sv
bench/tb_ortho_iso_camera_transform_unit.sv
